// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the codec checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// shared types and constants of the splay prefix codec
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned ALPHABET = 256;
  localparam int unsigned NODES    = 2 * ALPHABET + 1;
  localparam int unsigned NODE_W   = 10;  // node index 0..512
  localparam int unsigned INT_W    = 8;   // internal node index 0..255
  localparam int unsigned SYM_W    = 9;   // symbol 0..256
  localparam int unsigned SP_W     = 9;   // stack pointer 0..256

  localparam logic [SYM_W-1:0]  SYM_END   = SYM_W'(ALPHABET);
  localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(ALPHABET);
  localparam logic [NODE_W-1:0] LEAF_END  = NODE_W'(2 * ALPHABET);
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [INT_W-1:0]  wdata;
    logic [NODE_W-1:0] raddr;
  } par_req_t;

  typedef struct packed {
    logic              we;
    logic [INT_W-1:0]  waddr;
    logic [NODE_W-1:0] wdata;
    logic [INT_W-1:0]  raddr;
  } chd_req_t;

  typedef struct packed {
    logic             we;
    logic [INT_W-1:0] waddr;
    logic             wdata;
    logic [INT_W-1:0] raddr;
  } stk_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] value;
    logic             last;
    logic             fin;
  } res_t;

endpackage

// ===== rtl/spc_ram.sv =====
// ----------------------------------------------------------------------------
// spc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module spc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/spc_ctrl.sv =====
// ----------------------------------------------------------------------------
// spc_ctrl
// sequencer: tree init sweep, path walk, bit packing, decode walk, semi-splay
// ----------------------------------------------------------------------------
module spc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [spc_pkg::SYM_W-1:0]    in_value_i,
  input  logic                         out_free_i,
  output logic                         push_o,
  output spc_pkg::res_t                res_o,
  output spc_pkg::par_req_t            par_o,
  input  logic [spc_pkg::INT_W-1:0]    par_rdata_i,
  output spc_pkg::chd_req_t            lch_o,
  input  logic [spc_pkg::NODE_W-1:0]   lch_rdata_i,
  output spc_pkg::chd_req_t            rch_o,
  input  logic [spc_pkg::NODE_W-1:0]   rch_rdata_i,
  output spc_pkg::stk_req_t            stk_o,
  input  logic                         stk_rdata_i
);

  localparam logic [4:0] ST_INIT   = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_CPAR   = 5'd2;
  localparam logic [4:0] ST_CRCH   = 5'd3;
  localparam logic [4:0] ST_CPUSH  = 5'd4;
  localparam logic [4:0] ST_CPOP   = 5'd5;
  localparam logic [4:0] ST_CBIT   = 5'd6;
  localparam logic [4:0] ST_SP0    = 5'd7;
  localparam logic [4:0] ST_SP1    = 5'd8;
  localparam logic [4:0] ST_SP2    = 5'd9;
  localparam logic [4:0] ST_SP3    = 5'd10;
  localparam logic [4:0] ST_SP4    = 5'd11;
  localparam logic [4:0] ST_SP5    = 5'd12;
  localparam logic [4:0] ST_SPEND  = 5'd13;
  localparam logic [4:0] ST_CFLUSH = 5'd14;
  localparam logic [4:0] ST_ERD    = 5'd15;
  localparam logic [4:0] ST_ESEL   = 5'd16;
  localparam logic [4:0] ST_FIN    = 5'd17;

  logic [4:0]                  state_q, state_d;
  logic [spc_pkg::NODE_W-1:0]  a_q, a_d, b_q, b_d, init_q, init_d;
  logic [spc_pkg::INT_W-1:0]   c_q, c_d, d_q, d_d, dnode_q, dnode_d;
  logic [spc_pkg::INT_W-1:0]   pend_q, pend_d, byte_q, byte_d;
  logic [spc_pkg::SP_W-1:0]    sp_q, sp_d;
  logic [spc_pkg::SYM_W-1:0]   sym_q, sym_d, hold_val_q, hold_val_d;
  logic [2:0]                  bitpos_q, bitpos_d;
  logic [3:0]                  bi_q, bi_d;
  logic                        done_q, done_d, dir_q;
  logic                        hold_vld_q, hold_vld_d, hold_end_q, hold_end_d;
  logic                        fin_end_q, fin_end_d;

  logic                        emit_req, emit_end, emit_ok;
  logic [spc_pkg::SYM_W-1:0]   emit_val;
  logic [spc_pkg::INT_W-1:0]   newpend;
  logic [spc_pkg::NODE_W-1:0]  par_ext, c_ext, d_ext, nsel, init_m1;

  assign par_ext = spc_pkg::NODE_W'(par_rdata_i);
  assign c_ext   = spc_pkg::NODE_W'(c_q);
  assign d_ext   = spc_pkg::NODE_W'(d_q);
  assign init_m1 = init_q - 1'b1;
  assign newpend = pend_q | (spc_pkg::INT_W'(stk_rdata_i) << bitpos_q);
  assign nsel    = byte_q[bi_q[2:0]] ? rch_rdata_i : lch_rdata_i;
  assign emit_ok = !hold_vld_q || out_free_i;

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    c_d        = c_q;
    d_d        = d_q;
    init_d     = init_q;
    dnode_d    = dnode_q;
    pend_d     = pend_q;
    byte_d     = byte_q;
    sp_d       = sp_q;
    sym_d      = sym_q;
    bitpos_d   = bitpos_q;
    bi_d       = bi_q;
    done_d     = done_q;
    hold_vld_d = hold_vld_q;
    hold_val_d = hold_val_q;
    hold_end_d = hold_end_q;
    fin_end_d  = fin_end_q;
    emit_req   = 1'b0;
    emit_end   = 1'b0;
    emit_val   = '0;
    push_o     = 1'b0;
    res_o      = '{value: hold_val_q, last: 1'b0, fin: hold_end_q};
    in_ready_o = 1'b0;
    par_o      = '{we: 1'b0, waddr: a_q, wdata: d_q, raddr: a_q};
    lch_o      = '{we: 1'b0, waddr: d_q, wdata: a_q, raddr: dnode_q};
    rch_o      = '{we: 1'b0, waddr: d_q, wdata: a_q, raddr: dnode_q};
    stk_o      = '{we: 1'b0, waddr: sp_q[spc_pkg::INT_W-1:0], wdata: 1'b0,
                   raddr: sp_q[spc_pkg::INT_W-1:0]};

    case (state_q)
      ST_INIT: begin
        // balanced tree: parent (i-1)/2, children 2i+1 and 2i+2
        par_o.we    = 1'b1;
        par_o.waddr = init_q;
        par_o.wdata = (init_q == '0) ? '0 : spc_pkg::INT_W'(init_m1 >> 1);
        lch_o.we    = (init_q < spc_pkg::LEAF_BASE);
        lch_o.waddr = init_q[spc_pkg::INT_W-1:0];
        lch_o.wdata = {init_q[spc_pkg::NODE_W-2:0], 1'b1};
        rch_o.we    = (init_q < spc_pkg::LEAF_BASE);
        rch_o.waddr = init_q[spc_pkg::INT_W-1:0];
        rch_o.wdata = {init_q[spc_pkg::NODE_W-2:0], 1'b0} + 2'd2;
        if (init_q == spc_pkg::NODE_LAST) begin
          state_d = ST_IDLE;
        end else begin
          init_d = init_q + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_FIN;
          if (!done_q) begin
            if (!dir_q) begin
              if (in_value_i <= spc_pkg::SYM_END) begin
                sym_d   = in_value_i;
                a_d     = spc_pkg::NODE_W'(in_value_i) + spc_pkg::LEAF_BASE;
                sp_d    = '0;
                state_d = ST_CPAR;
              end
            end else begin
              byte_d  = in_value_i[spc_pkg::INT_W-1:0];
              bi_d    = '0;
              state_d = ST_ERD;
            end
          end
        end
      end
      ST_CPAR: begin
        par_o.raddr = a_q;
        state_d     = ST_CRCH;
      end
      ST_CRCH: begin
        rch_o.raddr = par_rdata_i;
        c_d         = par_rdata_i;
        state_d     = ST_CPUSH;
      end
      ST_CPUSH: begin
        stk_o.we    = !sp_q[spc_pkg::SP_W-1];
        stk_o.wdata = (rch_rdata_i == a_q);
        if (!sp_q[spc_pkg::SP_W-1]) begin
          sp_d = sp_q + 1'b1;
        end
        a_d     = c_ext;
        state_d = (c_q == '0) ? ST_CPOP : ST_CPAR;
      end
      ST_CPOP: begin
        if (sp_q == '0) begin
          a_d     = spc_pkg::NODE_W'(sym_q) + spc_pkg::LEAF_BASE;
          state_d = ST_SP0;
        end else begin
          sp_d        = sp_q - 1'b1;
          stk_o.raddr = spc_pkg::INT_W'(sp_q - 1'b1);
          state_d     = ST_CBIT;
        end
      end
      ST_CBIT: begin
        if (bitpos_q == 3'd7) begin
          emit_req = 1'b1;
          emit_val = spc_pkg::SYM_W'(newpend);
          if (emit_ok) begin
            pend_d   = '0;
            bitpos_d = '0;
            state_d  = ST_CPOP;
          end
        end else begin
          pend_d   = newpend;
          bitpos_d = bitpos_q + 1'b1;
          state_d  = ST_CPOP;
        end
      end
      ST_SP0: begin
        par_o.raddr = a_q;
        state_d     = ST_SP1;
      end
      ST_SP1: begin
        par_o.raddr = par_ext;
        c_d         = par_rdata_i;
        state_d     = (par_rdata_i == '0) ? ST_SPEND : ST_SP2;
      end
      ST_SP2: begin
        d_d         = par_rdata_i;
        lch_o.raddr = par_rdata_i;
        rch_o.raddr = par_rdata_i;
        state_d     = ST_SP3;
      end
      ST_SP3: begin
        // hang a under the grandparent in place of the parent's sibling
        if (c_ext == lch_rdata_i) begin
          b_d      = rch_rdata_i;
          rch_o.we = 1'b1;
        end else begin
          b_d      = lch_rdata_i;
          lch_o.we = 1'b1;
        end
        lch_o.raddr = c_q;
        state_d     = ST_SP4;
      end
      ST_SP4: begin
        lch_o.waddr = c_q;
        lch_o.wdata = b_q;
        rch_o.waddr = c_q;
        rch_o.wdata = b_q;
        if (a_q == lch_rdata_i) begin
          lch_o.we = 1'b1;
        end else begin
          rch_o.we = 1'b1;
        end
        par_o.we    = 1'b1;
        par_o.waddr = a_q;
        par_o.wdata = d_q;
        state_d     = ST_SP5;
      end
      ST_SP5: begin
        par_o.we    = 1'b1;
        par_o.waddr = b_q;
        par_o.wdata = c_q;
        a_d         = d_ext;
        state_d     = (d_q == '0) ? ST_SPEND : ST_SP0;
      end
      ST_SPEND: begin
        if (!dir_q) begin
          state_d = (sym_q == spc_pkg::SYM_END) ? ST_CFLUSH : ST_FIN;
        end else if (sym_q == spc_pkg::SYM_END) begin
          done_d  = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_ERD;
        end
      end
      ST_CFLUSH: begin
        if (bitpos_q != '0) begin
          emit_req = 1'b1;
          emit_val = spc_pkg::SYM_W'(pend_q);
          if (emit_ok) begin
            pend_d    = '0;
            bitpos_d  = '0;
            done_d    = 1'b1;
            fin_end_d = 1'b1;
            state_d   = ST_FIN;
          end
        end else begin
          done_d    = 1'b1;
          fin_end_d = 1'b1;
          state_d   = ST_FIN;
        end
      end
      ST_ERD: begin
        state_d = bi_q[3] ? ST_FIN : ST_ESEL;
      end
      ST_ESEL: begin
        bi_d = bi_q + 1'b1;
        if (nsel >= spc_pkg::LEAF_BASE) begin
          emit_req = 1'b1;
          emit_val = spc_pkg::SYM_W'(nsel - spc_pkg::LEAF_BASE);
          emit_end = (nsel == spc_pkg::LEAF_END);
          if (emit_ok) begin
            dnode_d = '0;
            a_d     = nsel;
            sym_d   = spc_pkg::SYM_W'(nsel - spc_pkg::LEAF_BASE);
            state_d = ST_SP0;
          end else begin
            bi_d = bi_q;
          end
        end else begin
          dnode_d = nsel[spc_pkg::INT_W-1:0];
          state_d = ST_ERD;
        end
      end
      ST_FIN: begin
        if (hold_vld_q) begin
          if (out_free_i) begin
            push_o     = 1'b1;
            res_o.last = 1'b1;
            res_o.fin  = hold_end_q | fin_end_q;
            hold_vld_d = 1'b0;
            fin_end_d  = 1'b0;
            state_d    = ST_IDLE;
          end
        end else begin
          fin_end_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // one result is held back so the last one of a beat can be marked
    if (emit_req && emit_ok) begin
      push_o     = hold_vld_q;
      hold_vld_d = 1'b1;
      hold_val_d = emit_val;
      hold_end_d = emit_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      init_q     <= '0;
      done_q     <= 1'b0;
      dir_q      <= 1'b0;
      hold_vld_q <= 1'b0;
      fin_end_q  <= 1'b0;
      pend_q     <= '0;
      bitpos_q   <= '0;
      dnode_q    <= '0;
    end else begin
      state_q    <= state_d;
      init_q     <= init_d;
      done_q     <= done_d;
      hold_vld_q <= hold_vld_d;
      fin_end_q  <= fin_end_d;
      pend_q     <= pend_d;
      bitpos_q   <= bitpos_d;
      dnode_q    <= dnode_d;
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    d_q        <= d_d;
    sp_q       <= sp_d;
    sym_q      <= sym_d;
    byte_q     <= byte_d;
    bi_q       <= bi_d;
    hold_val_q <= hold_val_d;
    hold_end_q <= hold_end_d;
  end

endmodule

// ===== rtl/splay_prefix_codec_core.sv =====
// ----------------------------------------------------------------------------
// splay_prefix_codec_core
// adaptive semi-splayed prefix code: symbols to packed bytes, or back
// ----------------------------------------------------------------------------
//  channel   dir  signals                         beat content
//  s_axis    in   tvalid tready tdata[15:0]       symbol (compress) or byte
//  m_axis    out  tvalid tready tdata tlast tuser packed byte or symbol
//  cfg       in   cfg_we_i cfg_wdata_i            direction, 1 = expand
//
//  after reset a sweep loads the balanced tree; no input is taken
//  meanwhile
//  compress: a walk of the path from leaf to root, the packing of its
//  bits root first, then semi-splay steps, each of which hangs the node
//  under its grandparent and climbs two levels
//  expand: a read and a select per input bit, plus a splay for each symbol
//  the pace is set by the registered reads of the tree rams; output stalls
//  only pause the sequencer
// ----------------------------------------------------------------------------
module splay_prefix_codec_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // direction
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [8:0] in_value, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [8:0] out_value, rest zero
  output logic        m_axis_tlast,   // out_last
  output logic        m_axis_tuser    // [0] out_end
);

  spc_pkg::par_req_t           par;
  spc_pkg::chd_req_t           lch, rch;
  spc_pkg::stk_req_t           stk;
  spc_pkg::res_t               res;
  logic                        push, out_free;
  logic [spc_pkg::INT_W-1:0]   par_rdata;
  logic [spc_pkg::NODE_W-1:0]  lch_rdata, rch_rdata;
  logic                        stk_rdata;

  // output register: one result beat parked here while the sequencer moves on
  logic                        out_vld_q;
  spc_pkg::res_t               out_q;

  assign out_free = !out_vld_q || m_axis_tready;

  spc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata[spc_pkg::SYM_W-1:0]),
    .out_free_i (out_free),
    .push_o     (push),
    .res_o      (res),
    .par_o      (par),
    .par_rdata_i(par_rdata),
    .lch_o      (lch),
    .lch_rdata_i(lch_rdata),
    .rch_o      (rch),
    .rch_rdata_i(rch_rdata),
    .stk_o      (stk),
    .stk_rdata_i(stk_rdata)
  );

  // parent of every node, leaves included
  spc_ram #(.WIDTH(spc_pkg::INT_W), .DEPTH(spc_pkg::NODES)) u_par (
    .clk_i(clk_i), .we_i(par.we), .waddr_i(par.waddr), .wdata_i(par.wdata),
    .raddr_i(par.raddr), .rdata_o(par_rdata)
  );

  // left and right children of internal nodes
  spc_ram #(.WIDTH(spc_pkg::NODE_W), .DEPTH(spc_pkg::ALPHABET)) u_lch (
    .clk_i(clk_i), .we_i(lch.we), .waddr_i(lch.waddr), .wdata_i(lch.wdata),
    .raddr_i(lch.raddr), .rdata_o(lch_rdata)
  );

  spc_ram #(.WIDTH(spc_pkg::NODE_W), .DEPTH(spc_pkg::ALPHABET)) u_rch (
    .clk_i(clk_i), .we_i(rch.we), .waddr_i(rch.waddr), .wdata_i(rch.wdata),
    .raddr_i(rch.raddr), .rdata_o(rch_rdata)
  );

  // path bits gathered leaf to root, replayed root first
  spc_ram #(.WIDTH(1), .DEPTH(spc_pkg::ALPHABET)) u_stk (
    .clk_i(clk_i), .we_i(stk.we), .waddr_i(stk.waddr), .wdata_i(stk.wdata),
    .raddr_i(stk.raddr), .rdata_o(stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = 16'(out_q.value);
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.fin;

endmodule

// ===== rtl/spc_checker.sv =====
// ----------------------------------------------------------------------------
// spc_checker
// port-level checks of the codec, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  `SPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "out beat dropped")
  `SPC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "out moved")
  `SPC_ASSERT_NOW(a_end_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "end beat not last")
  `SPC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")

endmodule

bind splay_prefix_codec_core spc_checker u_spc_checker (.*);

// ===== sim/splay_prefix_codec_core_test.sv =====
// ----------------------------------------------------------------------------
// splay_prefix_codec_core_test
// self-checking bench: a local splay-tree codec predicts every output beat
// while symbols are compressed and bytes expanded on a shared adaptive tree
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module splay_prefix_codec_core_test;

  localparam int unsigned SETTLE = 3000;  // worst-case busy time of a silent item

  // predictor state, one copy of the code tree plus packer and walker
  typedef struct {
    logic [9:0] up [0:512];
    logic [9:0] lo [0:255];
    logic [9:0] hi [0:255];
    logic [7:0] acc;
    logic [2:0] fill;
    logic [9:0] walk;
    bit         done;
    bit         dir;
  } codec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  codec_t        cs;
  codec_t        cs_keep;
  spc_pkg::res_t batch_q [$];     // beats caused by the item being predicted
  spc_pkg::res_t beats_due [$];   // beats still awaited from the block
  int            mismatches = 0;
  bit            idle_on = 1'b1;
  int            stall_left = 0;

  splay_prefix_codec_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void tree_reset();
    cs.up[0] = '0;
    for (int i = 1; i <= 512; i++) cs.up[i] = 10'((i - 1) >> 1);
    for (int i = 0; i < 256; i++) begin
      cs.lo[i] = 10'(2 * i + 1);
      cs.hi[i] = 10'(2 * i + 2);
    end
    cs.acc  = '0;
    cs.fill = '0;
    cs.walk = '0;
    cs.done = 1'b0;
    cs.dir  = 1'b0;
  endfunction

  function automatic void push_beat(logic [8:0] v, bit fin);
    spc_pkg::res_t r;
    r.value = v;
    r.last  = 1'b0;
    r.fin   = fin;
    batch_q.push_back(r);
  endfunction

  // semi-splay along the leaf's path: each pair of levels rotates up
  function automatic void splay_leaf(logic [8:0] sym);
    logic [9:0] a, b, c, d;
    a = 10'(sym) + spc_pkg::LEAF_BASE;
    do begin
      c = cs.up[a];
      if (c != 0) begin
        d = cs.up[c];
        b = cs.lo[d];
        if (c == b) begin
          b = cs.hi[d];
          cs.hi[d] = a;
        end else begin
          cs.lo[d] = a;
        end
        if (a == cs.lo[c]) cs.lo[c] = b;
        else cs.hi[c] = b;
        cs.up[a] = d;
        cs.up[b] = c;
        a = d;
      end else begin
        a = c;
      end
    end while (a != 0);
  endfunction

  function automatic void pack_symbol(logic [8:0] sym);
    bit         path [$];
    logic [9:0] a, u;
    a = 10'(sym) + spc_pkg::LEAF_BASE;
    do begin
      u = cs.up[a];
      path.push_front(cs.hi[u] == a);  // root-first order
      a = u;
    end while (a != 0);
    foreach (path[i]) begin
      if (path[i]) cs.acc[cs.fill] = 1'b1;
      if (cs.fill == 3'd7) begin
        push_beat({1'b0, cs.acc}, 1'b0);
        cs.acc = '0;
      end
      cs.fill = cs.fill + 3'd1;
    end
    splay_leaf(sym);
    if (sym == spc_pkg::SYM_END) begin
      if (cs.fill != 0) begin
        push_beat({1'b0, cs.acc}, 1'b0);
        cs.acc  = '0;
        cs.fill = '0;
      end
      if (batch_q.size() > 0) batch_q[$].fin = 1'b1;
      cs.done = 1'b1;
    end
  endfunction

  // one decode step of the expand walk
  function automatic void walk_bit(bit b);
    logic [9:0] node;
    node = (cs.walk >= spc_pkg::LEAF_BASE) ? 10'd0 : cs.walk;
    node = b ? cs.hi[node[7:0]] : cs.lo[node[7:0]];
    if (node >= spc_pkg::LEAF_BASE) begin
      splay_leaf(9'(node - spc_pkg::LEAF_BASE));
      cs.walk = '0;
      push_beat(9'(node - spc_pkg::LEAF_BASE), node == spc_pkg::LEAF_END);
      if (node == spc_pkg::LEAF_END) cs.done = 1'b1;
    end else begin
      cs.walk = node;
    end
  endfunction

  // direction that leads from the current walk node toward the end marker
  function automatic bit toward_end();
    logic [9:0] a, p;
    a = spc_pkg::LEAF_END;
    while (a != 0) begin
      p = cs.up[a];
      if (p == cs.walk) return cs.hi[p] == a;
      a = p;
    end
    return 1'b0;
  endfunction

  function automatic void codec_step(logic [8:0] v);
    batch_q.delete();
    if (cs.done) return;
    if (!cs.dir) begin
      if (v > spc_pkg::SYM_END) return;  // out-of-range symbol is dropped
      pack_symbol(v);
    end else begin
      for (int i = 0; i < 8 && !cs.done; i++) walk_bit(v[i]);
    end
    if (batch_q.size() > 0) batch_q[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(logic [8:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, v};
    codec_step(v);
    foreach (batch_q[i]) beats_due.push_back(batch_q[i]);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // expand byte that keeps the stream open: redraw while it would decode the end marker
  task automatic send_open_byte(logic [8:0] v);
    bit ended;
    for (int t = 0; t < 64; t++) begin
      cs_keep = cs;
      codec_step(v);
      ended = cs.done;
      cs = cs_keep;
      if (!ended) break;
      v = {v[8], 8'($urandom_range(0, 255))};
    end
    send_item(v);
  endtask

  // drain, let silent items finish, then write the direction register
  task automatic set_direction(bit d);
    s_axis_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    cs.dir = d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [8:0] pick_symbol(ref logic [7:0] hot [8]);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return {1'b0, hot[$urandom_range(0, 7)]};
    if (r < 90) return 9'($urandom_range(0, 255));
    return 9'($urandom_range(257, 511));  // noise, ignored by the block
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    spc_pkg::res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: out_value %0d", m_axis_tdata[8:0]);
        mismatches++;
      end else begin
        want = beats_due.pop_front();
        if (m_axis_tdata[8:0] != want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, m_axis_tdata[8:0]);
          mismatches++;
        end
        if (m_axis_tlast != want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser != want.fin) begin
          $error("out_end: expected %0b, got %0b", want.fin, m_axis_tuser);
          mismatches++;
        end
      end
    end
    // receiver back-pressure in random bursts
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_compress();
    logic [8:0] syms [12] = '{9'd0, 9'd255, 9'd1, 9'd128, 9'd255, 9'd255, 9'd0,
                              9'd257, 9'd511, 9'd300, 9'd7, 9'd64};
    set_direction(1'b0);
    foreach (syms[i]) send_item(syms[i]);
  endtask

  // expand picks up the adapted tree left by compress
  task automatic test_directed_expand();
    logic [8:0] bytes [9] = '{9'h000, 9'h0FF, 9'h055, 9'h0AA, 9'h1FF, 9'h100,
                              9'h080, 9'h001, 9'h13C};
    set_direction(1'b1);
    foreach (bytes[i]) send_open_byte(bytes[i]);
  endtask

  task automatic test_random_traffic();
    logic [7:0] hot [8];
    for (int ph = 0; ph < 6; ph++) begin
      foreach (hot[i]) hot[i] = 8'($urandom_range(0, 255));
      set_direction(ph[0]);
      for (int n = 0; n < 38; n++) begin
        if (!cs.dir) send_item(pick_symbol(hot));
        else send_open_byte(9'($urandom_range(0, 511)));
      end
    end
  endtask

  // no idling from here on; one end marker, then input that must be ignored
  task automatic test_end_of_stream();
    logic [7:0] hot [8];
    logic [7:0] b;
    bit         via_expand;
    foreach (hot[i]) hot[i] = 8'($urandom_range(0, 255));
    via_expand = $urandom_range(0, 1);
    idle_on = 1'b0;
    set_direction(via_expand);
    for (int n = 0; n < 12; n++) begin
      if (!cs.dir) send_item(pick_symbol(hot));
      else send_open_byte(9'($urandom_range(0, 511)));
    end
    if (!via_expand) begin
      send_item(spc_pkg::SYM_END);
    end else begin
      // steer the walk toward the end marker leaf, bits after it are dropped
      while (!cs.done) begin
        cs_keep = cs;
        for (int i = 0; i < 8; i++) begin
          b[i] = cs.done ? 1'($urandom_range(0, 1)) : toward_end();
          if (!cs.done) walk_bit(b[i]);
        end
        cs = cs_keep;
        send_item({1'b0, b});
      end
    end
    for (int n = 0; n < 6; n++) send_item(9'($urandom_range(0, 256)));
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    tree_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_compress();
    test_directed_expand();
    test_random_traffic();
    test_end_of_stream();

    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_ram.sv
rtl/spc_ctrl.sv
rtl/splay_prefix_codec_core.sv
rtl/spc_checker.sv
sim/splay_prefix_codec_core_test.sv
